[rtl/core/asfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfc_pkg
// Shared formats, register indexes and the u8 decode table of the sample
// format converter.
// ----------------------------------------------------------------------------
package asfc_pkg;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_F32 = 2'd2;

  localparam logic REG_INPUT_FORMAT  = 1'b0;
  localparam logic REG_OUTPUT_FORMAT = 1'b1;

  // register stages inside each encoder
  localparam int unsigned LAT_ENC = 4;

  typedef struct packed {
    logic [1:0]  ofmt;
    logic [31:0] fbits;
  } meta_t;

  typedef logic [31:0] u8_lut_t [256];

  // float bits of ((x / 255) * 2) - 1, every step single precision, nearest even
  function automatic u8_lut_t build_u8_lut();
    u8_lut_t lut;
    longint  num;
    longint  n;
    longint  r;
    longint  m;
    int      s;
    int      k;
    int      ld;
    int      e;
    logic    sgn;
    logic    g;
    logic    rest;
    logic    lsb;
    logic    found;
    logic [31:0] ev;
    for (int x = 0; x < 256; x++) begin
      if (x == 0) begin
        lut[x] = 32'hBF80_0000;
      end else if (x == 255) begin
        lut[x] = 32'h3F80_0000;
      end else begin
        found = 1'b0;
        s = 0;
        for (int i = 0; i < 40; i++) begin
          num = longint'(x) <<< i;
          if (!found && (num / 255) >= 64'sd8388608) begin
            found = 1'b1;
            s = i;
          end
        end
        // quotient never terminates, so the sticky part is always set
        n = (longint'(x) <<< s) / 255;
        g = 1'(((longint'(x) <<< (s + 1)) / 255) & 64'sd1);
        n = n + longint'(g);
        if (n == 64'sd16777216) begin
          n = n >>> 1;
          s = s - 1;
        end
        r = (n <<< 1) - (64'sd1 <<< s);
        sgn = (r < 0);
        m = sgn ? -r : r;
        ld = 0;
        for (int i = 0; i < 63; i++) begin
          if (((m >>> i) & 64'sd1) != 0) ld = i;
        end
        if (ld > 23) begin
          k = ld - 23;
          g = 1'((m >>> (k - 1)) & 64'sd1);
          rest = ((m & ((64'sd1 <<< (k - 1)) - 1)) != 0);
          lsb = 1'((m >>> k) & 64'sd1);
          m = m >>> k;
          if (g && (rest || lsb)) m = m + 1;
          if (m == 64'sd16777216) begin
            m = m >>> 1;
            k = k + 1;
          end
        end else begin
          k = ld - 23;
          m = m <<< (23 - ld);
        end
        e = 23 + k - s + 127;
        ev = 32'(e);
        lut[x] = {sgn, ev[7:0], m[22:0]};
      end
    end
    return lut;
  endfunction

  localparam u8_lut_t U8_LUT = build_u8_lut();

endpackage
`default_nettype wire

[rtl/core/asfc_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfc_decode
// Turns a raw u8, s16 or float32 sample into float32 bits, one register stage.
// ----------------------------------------------------------------------------
module asfc_decode
  import asfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [1:0]  in_fmt_i,
  input  wire logic [31:0] sample_i,
  output logic      [31:0] fbits_o
);

  logic [31:0] fbits_d;
  logic [31:0] fbits_q;
  logic [15:0] mag;
  logic [3:0]  lead;
  logic [38:0] norm;
  logic [7:0]  expo;
  logic [31:0] s16_bits;

  always_comb begin
    mag = sample_i[15] ? (~sample_i[15:0] + 16'd1) : sample_i[15:0];
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) lead = 4'(i);
    end
    norm = {23'd0, mag} << (5'd23 - {1'b0, lead});
    // value / 32768 moves the exponent down by fifteen
    expo = 8'd112 + {4'd0, lead};
    if (mag == 16'd0) begin
      s16_bits = '0;
    end else begin
      s16_bits = {sample_i[15], expo, norm[22:0]};
    end
    case (in_fmt_i)
      FMT_U8:  fbits_d = U8_LUT[sample_i[7:0]];
      FMT_S16: fbits_d = s16_bits;
      default: fbits_d = sample_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fbits_q <= fbits_d;
    end
  end

  assign fbits_o = fbits_q;

endmodule
`default_nettype wire

[rtl/core/asfc_u8_enc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfc_u8_enc
// Float32 to u8: (f + 1) * 127.5 with single-precision rounding, truncated
// and saturated, over four register stages.
// ----------------------------------------------------------------------------
module asfc_u8_enc
  import asfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] fbits_i,
  output logic      [7:0]  res_o,
  output logic             clip_o
);

  localparam logic [27:0] ONE_FX = 28'h800_0000;

  typedef struct packed {
    logic nan;
    logic big;
    logic sgn;
    logic ssgn;
  } flags_t;

  // stage 1: fixed point f + 1 with sticky
  logic        sgn;
  logic [7:0]  ex;
  logic [7:0]  eeff;
  logic [23:0] sig;
  logic [6:0]  rsh;
  logic [27:0] x28;
  logic [27:0] mf;
  logic        st;
  flags_t      e1_flags_d, e1_flags_q;
  logic [28:0] e1_smag_d, e1_smag_q;
  logic        e1_st_q;

  always_comb begin
    sgn  = fbits_i[31];
    ex   = fbits_i[30:23];
    sig  = {ex != 8'd0, fbits_i[22:0]};
    eeff = (ex == 8'd0) ? 8'd1 : ex;
    rsh  = 7'(8'd127 - eeff);
    x28  = {sig, 4'd0};
    if (rsh >= 7'd28) begin
      mf = '0;
      st = (sig != 24'd0);
    end else begin
      mf = x28 >> rsh;
      st = ((x28 & ~(28'hFFF_FFFF << rsh)) != 28'd0);
    end
    e1_flags_d.nan = (ex == 8'hFF) && (fbits_i[22:0] != 23'd0);
    e1_flags_d.big = ex[7];
    e1_flags_d.sgn = sgn;
    if (!sgn) begin
      e1_smag_d = {1'b0, mf} + {1'b0, ONE_FX};
      e1_flags_d.ssgn = 1'b0;
    end else if (mf > ONE_FX) begin
      e1_smag_d = {1'b0, mf - ONE_FX};
      e1_flags_d.ssgn = 1'b1;
    end else begin
      // dropped bits of a negative f lower the sum by a fraction of an lsb
      e1_smag_d = {1'b0, ONE_FX - mf - {27'd0, st}};
      e1_flags_d.ssgn = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_flags_q <= e1_flags_d;
      e1_smag_q  <= e1_smag_d;
      e1_st_q    <= st;
    end
  end

  // stage 2: round the sum to 24 significant bits
  logic [4:0]  lead1;
  logic [2:0]  k1;
  logic [28:0] trunc1;
  logic        up1;
  flags_t      e2_flags_q;
  logic [29:0] e2_mv_d, e2_mv_q;

  always_comb begin
    lead1 = '0;
    for (int i = 0; i < 29; i++) begin
      if (e1_smag_q[i]) lead1 = 5'(i);
    end
    k1 = '0;
    trunc1 = '0;
    up1 = 1'b0;
    if (lead1 > 5'd23) begin
      k1 = 3'(lead1 - 5'd23);
      trunc1 = e1_smag_q >> k1;
      up1 = e1_smag_q[k1 - 3'd1] &
            (((e1_smag_q & ~(29'h1FFF_FFFF << (k1 - 3'd1))) != 29'd0) | e1_st_q | trunc1[0]);
      e2_mv_d = ({1'b0, trunc1} + {29'd0, up1}) << k1;
    end else begin
      e2_mv_d = {1'b0, e1_smag_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e2_flags_q <= e1_flags_q;
      e2_mv_q    <= e2_mv_d;
    end
  end

  // stage 3: times 255, the halving stays in the binary point
  flags_t      e3_flags_q;
  logic [37:0] e3_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e3_flags_q <= e2_flags_q;
      e3_p_q     <= ({8'd0, e2_mv_q} << 8) - {8'd0, e2_mv_q};
    end
  end

  // stage 4: round the product, truncate and saturate
  logic [5:0]  lead2;
  logic [3:0]  k2;
  logic [37:0] trunc2;
  logic        up2;
  logic [38:0] rnd2;
  logic [10:0] fl;
  logic [7:0]  res_d, res_q;
  logic        clip_d, clip_q;

  always_comb begin
    lead2 = '0;
    for (int i = 0; i < 38; i++) begin
      if (e3_p_q[i]) lead2 = 6'(i);
    end
    k2 = '0;
    trunc2 = '0;
    up2 = 1'b0;
    if (lead2 > 6'd23) begin
      k2 = 4'(lead2 - 6'd23);
      trunc2 = e3_p_q >> k2;
      up2 = e3_p_q[k2 - 4'd1] &
            (((e3_p_q & ~({38{1'b1}} << (k2 - 4'd1))) != 38'd0) | trunc2[0]);
      rnd2 = ({1'b0, trunc2} + {38'd0, up2}) << k2;
    end else begin
      rnd2 = {1'b0, e3_p_q};
    end
    fl = rnd2[38:28];
    if (e3_flags_q.nan) begin
      res_d = 8'd0;
      clip_d = 1'b1;
    end else if (e3_flags_q.big) begin
      res_d = e3_flags_q.sgn ? 8'd0 : 8'd255;
      clip_d = 1'b1;
    end else if (e3_flags_q.ssgn) begin
      res_d = 8'd0;
      clip_d = (fl != 11'd0);
    end else if (fl >= 11'd256) begin
      res_d = 8'd255;
      clip_d = 1'b1;
    end else begin
      res_d = fl[7:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule
`default_nettype wire

[rtl/core/asfc_s16_enc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfc_s16_enc
// Float32 to s16: f * 32767 with single-precision rounding, truncated and
// saturated, over four register stages.
// ----------------------------------------------------------------------------
module asfc_s16_enc
  import asfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] fbits_i,
  output logic      [15:0] res_o,
  output logic             clip_o
);

  typedef struct packed {
    logic       nan;
    logic       big;
    logic       tiny;
    logic       sgn;
    logic [7:0] ex;
  } flags_t;

  // stage 1: significand times 32767
  flags_t      e1_flags_d, e1_flags_q;
  logic [38:0] e1_p_q;

  always_comb begin
    e1_flags_d.sgn  = fbits_i[31];
    e1_flags_d.ex   = fbits_i[30:23];
    e1_flags_d.nan  = (fbits_i[30:23] == 8'hFF) && (fbits_i[22:0] != 23'd0);
    e1_flags_d.big  = fbits_i[30];
    // subnormals scale to far below one
    e1_flags_d.tiny = (fbits_i[30:23] == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_flags_q <= e1_flags_d;
      e1_p_q     <= 39'({1'b1, fbits_i[22:0]}) * 39'd32767;
    end
  end

  // stage 2: round the product to 24 significant bits
  logic [3:0]  k;
  logic [38:0] trunc;
  logic        up;
  flags_t      e2_flags_q;
  logic [39:0] e2_pr_d, e2_pr_q;

  always_comb begin
    k = e1_p_q[38] ? 4'd15 : 4'd14;
    trunc = e1_p_q >> k;
    up = e1_p_q[k - 4'd1] &
         (((e1_p_q & ~({39{1'b1}} << (k - 4'd1))) != 39'd0) | trunc[0]);
    e2_pr_d = ({1'b0, trunc} + {39'd0, up}) << k;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e2_flags_q <= e1_flags_q;
      e2_pr_q    <= e2_pr_d;
    end
  end

  // stage 3: integer part
  logic [7:0]  sh;
  flags_t      e3_flags_q;
  logic [16:0] e3_int_d, e3_int_q;

  always_comb begin
    sh = 8'd150 - e2_flags_q.ex;
    if (e2_flags_q.tiny || e2_flags_q.big || sh >= 8'd40) begin
      e3_int_d = '0;
    end else begin
      e3_int_d = 17'(e2_pr_q >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e3_flags_q <= e2_flags_q;
      e3_int_q   <= e3_int_d;
    end
  end

  // stage 4: saturate
  logic [15:0] res_d, res_q;
  logic        clip_d, clip_q;
  logic [16:0] neg_int;

  always_comb begin
    neg_int = ~e3_int_q + 17'd1;
    if (e3_flags_q.nan) begin
      res_d = 16'h0000;
      clip_d = 1'b1;
    end else if (e3_flags_q.big) begin
      res_d = e3_flags_q.sgn ? 16'h8000 : 16'h7FFF;
      clip_d = 1'b1;
    end else if (!e3_flags_q.sgn) begin
      if (e3_int_q >= 17'd32768) begin
        res_d = 16'h7FFF;
        clip_d = 1'b1;
      end else begin
        res_d = e3_int_q[15:0];
        clip_d = 1'b0;
      end
    end else if (e3_int_q >= 17'd32769) begin
      res_d = 16'h8000;
      clip_d = 1'b1;
    end else begin
      res_d = neg_int[15:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule
`default_nettype wire

[rtl/core/audio_sample_format_converter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_sample_format_converter_unit
// Converts u8, s16 or float32 samples to u8, s16 or float32 via float32.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock and passes it through one decode stage,
// four encode stages and the output register. All stages move together and
// hold while a finished sample waits at the output, so the sustained rate is
// one sample per cycle whenever the sink takes one per cycle. Formats: 0 u8,
// 1 s16, 2 or 3 float32; change them only when idle.
module audio_sample_format_converter_unit
  import asfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] sample_in
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,   // [31:0] sample_out
  output logic      [0:0]  m_axis_tuser_o    // [0] clipped
);

  logic [1:0]  in_fmt_q;
  logic [1:0]  out_fmt_q;
  logic        adv;
  logic [LAT_ENC:0] vld_q;
  logic [1:0]  ofmt_s1_q;
  meta_t       meta_q [1:LAT_ENC];
  logic [31:0] fbits;
  logic [7:0]  u8_res;
  logic        u8_clip;
  logic [15:0] s16_res;
  logic        s16_clip;
  logic        m_valid_q;
  logic [31:0] m_data_d, m_data_q;
  logic        m_clip_d, m_clip_q;
  logic [1:0]  m_fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fmt_q  <= FMT_F32;
      out_fmt_q <= FMT_F32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_FORMAT:  in_fmt_q  <= cfg_wdata_i;
        REG_OUTPUT_FORMAT: out_fmt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // whole pipe steps unless the output holds an item not yet taken
  assign adv = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  asfc_decode u_decode (
    .clk_i    (clk_i),
    .en_i     (adv),
    .in_fmt_i (in_fmt_q),
    .sample_i (s_axis_tdata_i),
    .fbits_o  (fbits)
  );

  asfc_u8_enc u_u8_enc (
    .clk_i   (clk_i),
    .en_i    (adv),
    .fbits_i (fbits),
    .res_o   (u8_res),
    .clip_o  (u8_clip)
  );

  asfc_s16_enc u_s16_enc (
    .clk_i   (clk_i),
    .en_i    (adv),
    .fbits_i (fbits),
    .res_o   (s16_res),
    .clip_o  (s16_clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LAT_ENC-1:0], s_axis_tvalid_i};
      m_valid_q <= vld_q[LAT_ENC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ofmt_s1_q <= out_fmt_q;
      meta_q[1] <= '{ofmt: ofmt_s1_q, fbits: fbits};
      for (int i = 2; i <= LAT_ENC; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      m_data_q <= m_data_d;
      m_clip_q <= m_clip_d;
      m_fmt_q  <= meta_q[LAT_ENC].ofmt;
    end
  end

  always_comb begin
    case (meta_q[LAT_ENC].ofmt)
      FMT_U8: begin
        m_data_d = {24'd0, u8_res};
        m_clip_d = u8_clip;
      end
      FMT_S16: begin
        m_data_d = {16'd0, s16_res};
        m_clip_d = s16_clip;
      end
      default: begin
        m_data_d = meta_q[LAT_ENC].fbits;
        m_clip_d = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_clip_q;

  a_u8_zero_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_fmt_q == FMT_U8 |-> m_axis_tdata_o[31:8] == 24'd0)
    else $error("u8 item with upper bits set");

  a_s16_zero_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_fmt_q == FMT_S16 |-> m_axis_tdata_o[31:16] == 16'd0)
    else $error("s16 item with upper bits set");

  a_float_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_fmt_q != FMT_U8 && m_fmt_q != FMT_S16 |-> !m_axis_tuser_o[0])
    else $error("float item flagged as clipped");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

[dv/tb_audio_sample_format_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_sample_format_converter_unit
// Stream testbench for the sample format converter: directed corner samples
// and random samples for every pair of formats, checked bit for bit against
// an exact integer model of the single-precision arithmetic.
// ----------------------------------------------------------------------------
module tb_audio_sample_format_converter_unit;
  import asfc_pkg::*;

  localparam logic [1:0] FMT_ALT = 2'd3;  // spare code, acts as float32

  // exact float value: m * 2^e, m normalized to 24 bits unless zero
  typedef struct {
    bit          s;
    bit          z;
    logic [24:0] m;
    int          e;
  } fval_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [1:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [31:0] sample_in
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [31:0] sample_out
  logic [0:0]  m_axis_tuser_o;        // [0] clipped

  audio_sample_format_converter_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [1:0]  in_fmt = FMT_F32;
  logic [1:0]  out_fmt = FMT_F32;
  logic [31:0] exp_sample_q[$];
  bit          exp_clip_q[$];
  bit          idle_en = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          n_err = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_clipped = 0;

  // ---------------------------------------------------------------- arithmetic

  function automatic fval_t fround(bit s, logic [127:0] mag, int e2, bit sticky);
    fval_t        r;
    int           ld;
    int           k;
    logic         g;
    logic         rest;
    logic [127:0] t;
    r.s = s;
    r.z = (mag == '0);
    r.m = '0;
    r.e = 0;
    if (r.z) return r;
    ld = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) ld = i;
    if (ld > 23) begin
      k = ld - 23;
      g = mag[k-1];
      rest = sticky || ((mag & ((128'd1 << (k - 1)) - 128'd1)) != '0);
      t = mag >> k;
      if (g && (rest || t[0])) t = t + 128'd1;
      if (t[24]) begin
        t = t >> 1;
        k++;
      end
      r.m = t[24:0];
      r.e = e2 + k;
    end else begin
      t = mag << (23 - ld);
      r.m = t[24:0];
      r.e = e2 - (23 - ld);
    end
    return r;
  endfunction

  function automatic logic [31:0] fbits(fval_t a);
    logic [7:0] be;
    if (a.z) return 32'h0;
    be = 8'(a.e + 23 + 127);
    return {a.s, be, a.m[22:0]};
  endfunction

  function automatic longint ftrunc(fval_t a);
    if (a.z) return 0;
    if (a.e >= 0) return longint'(a.m) <<< a.e;
    if (a.e < -40) return 0;
    return longint'(a.m) >>> (-a.e);
  endfunction

  function automatic logic [31:0] decode_to_float(logic [1:0] fmt, logic [31:0] raw);
    logic [127:0]       q;
    logic [127:0]       one;
    logic signed [15:0] v;
    fval_t              t1;
    bit                 neg;
    if (fmt == FMT_U8) begin
      if (raw[7:0] == 8'd0) return 32'hBF80_0000;
      q = {120'd0, raw[7:0]} << 40;
      t1 = fround(1'b0, q / 128'd255, -40, (q % 128'd255) != '0);
      // t1 * 2 is exact, then subtract one at the common exponent
      one = 128'd1 << (-(t1.e + 1));
      neg = (one > 128'(t1.m));
      return fbits(fround(neg, neg ? one - 128'(t1.m) : 128'(t1.m) - one, t1.e + 1, 1'b0));
    end
    v = raw[15:0];
    return fbits(fround(v < 0, 128'(v < 0 ? -int'(v) : int'(v)), -15, 1'b0));
  endfunction

  function automatic logic [31:0] encode_u8(logic [31:0] b, output bit clip);
    logic [7:0]   ef;
    logic [127:0] mant;
    logic [127:0] one;
    fval_t        a;
    fval_t        v;
    longint       t;
    int           ex;
    bit           neg;
    clip = 1'b0;
    ef = b[30:23];
    if (ef == 8'hFF && b[22:0] != '0) begin
      clip = 1'b1;
      return 32'd0;
    end
    // |f| >= 4 always saturates, |f| < 2^-60 leaves f + 1 at one
    if (ef >= 8'd129) begin
      clip = 1'b1;
      return b[31] ? 32'd0 : 32'd255;
    end
    if (ef < 8'd67) return 32'd127;
    ex = int'(ef) - 150;
    mant = {104'd0, 1'b1, b[22:0]};
    one = 128'd1 << (-ex);
    neg = b[31] && (mant > one);
    a = fround(neg, b[31] ? (neg ? mant - one : one - mant) : one + mant, ex, 1'b0);
    if (a.z) return 32'd0;
    v = fround(a.s, 128'(a.m) * 128'd255, a.e - 1, 1'b0);
    t = ftrunc(v);
    if (v.s) begin
      if (t >= 1) clip = 1'b1;
      return 32'd0;
    end
    if (t >= 256) begin
      clip = 1'b1;
      return 32'd255;
    end
    return 32'(t);
  endfunction

  function automatic logic [31:0] encode_s16(logic [31:0] b, output bit clip);
    logic [7:0] ef;
    fval_t      v;
    longint     t;
    longint     r;
    clip = 1'b0;
    ef = b[30:23];
    if (ef == 8'hFF && b[22:0] != '0) begin
      clip = 1'b1;
      return 32'd0;
    end
    if (ef >= 8'd128) begin
      clip = 1'b1;
      return b[31] ? 32'h8000 : 32'h7FFF;
    end
    if (ef < 8'd107) return 32'd0;
    v = fround(b[31], {104'd0, 1'b1, b[22:0]} * 128'd32767, int'(ef) - 150, 1'b0);
    t = ftrunc(v);
    if (v.s) begin
      if (t >= 32769) begin
        clip = 1'b1;
        return 32'h8000;
      end
      r = -t;
    end else begin
      if (t >= 32768) begin
        clip = 1'b1;
        return 32'h7FFF;
      end
      r = t;
    end
    return {16'd0, r[15:0]};
  endfunction

  function automatic logic [31:0] convert_sample(logic [1:0] ifmt, logic [1:0] ofmt,
                                                 logic [31:0] raw, output bit clip);
    logic [31:0] f;
    bit          in_float;
    clip = 1'b0;
    in_float = (ifmt != FMT_U8) && (ifmt != FMT_S16);
    f = in_float ? raw : decode_to_float(ifmt, raw);
    if (ofmt == FMT_U8) return encode_u8(f, clip);
    if (ofmt == FMT_S16) return encode_s16(f, clip);
    return f;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_sample(logic [31:0] d);
    bit c;
    @(posedge clk_i);
    if (idle_en && $urandom_range(99) < 9) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(3) == 0);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
      @(posedge clk_i);
    end
    // taken at the coming edge
    exp_sample_q.push_back(convert_sample(in_fmt, out_fmt, d, c));
    exp_clip_q.push_back(c);
    n_sent++;
  endtask

  task automatic stop_sending();
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (exp_sample_q.size() != 0) @(posedge clk_i);
    repeat (LAT_ENC + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_INPUT_FORMAT) in_fmt = val;
    else out_fmt = val;
  endtask

  task automatic set_formats(logic [1:0] ifmt, logic [1:0] ofmt);
    stop_sending();
    wait_drained();
    write_reg(REG_INPUT_FORMAT, ifmt);
    write_reg(REG_OUTPUT_FORMAT, ofmt);
  endtask

  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1))};
      2:       return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
      default: begin
        ex = 8'($urandom_range(100, 130));
        return {1'($urandom_range(1)), ex, 23'($urandom())};
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- sink side

  always @(posedge clk_i) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    else if (hold_req) hold_cnt <= 300;
  end

  always @(posedge clk_i) begin
    if (hold_cnt > 1 || (hold_req && hold_cnt == 0)) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= !idle_en || ($urandom_range(99) >= 9);
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_sample_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected sample %h", m_axis_tdata_o);
      end else begin
        if (m_axis_tdata_o !== exp_sample_q[0] || m_axis_tuser_o[0] !== exp_clip_q[0]) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp sample %h clip %0d, got sample %h clip %0d",
                     exp_sample_q[0], exp_clip_q[0], m_axis_tdata_o, m_axis_tuser_o[0]);
        end
        if (exp_clip_q[0]) n_clipped++;
        n_checked++;
        void'(exp_sample_q.pop_front());
        void'(exp_clip_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_passthrough();
    // float in, float out after reset: bits kept, nan payloads too
    send_sample(32'h7FC0_1234);
    send_sample(32'hFF80_0001);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    send_sample(32'h3F80_0000);
    send_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    set_formats(FMT_U8, FMT_F32);
    send_sample(32'hFFFF_FF00);
    send_sample(32'h0000_00FF);
    send_sample(32'h0000_007F);
    send_sample(32'h0000_0080);
    set_formats(FMT_S16, FMT_U8);
    send_sample(32'hFFFF_8000);
    send_sample(32'h0000_7FFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0001_FFFF);
    set_formats(FMT_F32, FMT_U8);
    send_sample(32'h7FC0_0000);  // nan
    send_sample(32'h7F80_0000);  // +inf saturates
    send_sample(32'hFF80_0000);  // -inf saturates
    send_sample(32'h4000_0000);  // 2.0 clips high
    send_sample(32'hC000_0000);  // -2.0 clips low
    send_sample(32'h3F80_0000);
    set_formats(FMT_ALT, FMT_S16);
    send_sample(32'h3F80_0000);
    send_sample(32'hBF80_0000);
    send_sample(32'hBF80_0040);  // just below -1
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    set_formats(FMT_S16, FMT_ALT);
    send_sample(32'h0000_8001);
    send_sample(32'h0000_0001);
  endtask

  task automatic test_random();
    for (int p = 0; p < 16; p++) begin
      set_formats(2'(p >> 2), 2'(p));
      idle_en = (p % 5 != 0);
      for (int i = 0; i < 26; i++)
        send_sample(in_fmt == FMT_U8 || in_fmt == FMT_S16 ? $urandom() : rand_float());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    set_formats(FMT_U8, FMT_S16);
    @(negedge clk_i);
    hold_req = 1'b1;
    repeat (40) send_sample($urandom());
    hold_req = 1'b0;
    // sender waits for all results before carrying on
    stop_sending();
    while (exp_sample_q.size() != 0) @(posedge clk_i);
    repeat (20) send_sample($urandom());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_passthrough();
    test_directed();
    test_random();
    test_backpressure();
    stop_sending();
    wait_drained();
    $display("covered all 16 format pairs, corner samples and output stalls");
    $display("%0d samples sent, %0d checked, %0d clipped", n_sent, n_checked, n_clipped);
    if (n_err == 0 && exp_sample_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
